### design/dof_equation_numbering_router_assert.svh
// Assertion helpers for the DOF equation-numbering router.
`ifndef DOF_EQUATION_NUMBERING_ROUTER_ASSERT_SVH
`define DOF_EQUATION_NUMBERING_ROUTER_ASSERT_SVH

// Same-cycle implication, switched off while reset is asserted.
`define DOFR_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define DOFR_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/dofr_pkg.sv
package dofr_pkg;

  // Width of the intermediate DOF number before the range check
  localparam int IXW = 18;
  // Width of the row, column, equation and total result fields
  localparam int OUT_W = 13;

  typedef enum logic [2:0] {
    CMD_CLEAR   = 3'd0,
    CMD_MARK    = 3'd1,
    CMD_NUMBER  = 3'd2,
    CMD_ROUTE_K = 3'd3,
    CMD_ROUTE_C = 3'd4,
    CMD_QUERY   = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_RANGE      = 2'd1,
    STATUS_UNNUMBERED = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    TGT_KCC    = 3'd0,
    TGT_KCS    = 3'd1,
    TGT_KSSCST = 3'd2,
    TGT_CC     = 3'd3,
    TGT_NONE   = 3'd4
  } target_e;

  typedef enum logic [1:0] {
    REG_NODE_COUNT    = 2'd0,
    REG_ELEMENT_COUNT = 2'd1,
    REG_MPC_COUNT     = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RESP,
    ST_CLEAR,
    ST_NUMBER
  } state_e;

  typedef struct packed {
    logic           ok;
    logic [IXW-1:0] idx;
  } dof_addr_t;

endpackage

### design/dof_equation_numbering_router.sv
// DOF equation-numbering router. A request is taken when start is high and busy is low; its
// result appears on done_o for exactly one cycle, registered from the response state that
// follows the accept, and cannot be held off by the receiver. Mark, route and query requests
// read both DOF entries of the table memory in the accept cycle and finish in the next one,
// so busy covers only the response state, and no new request is taken while one is being
// answered. The table memory has one write port, which sets the length of the passes: a
// clear request, reset, and an idle write to node_count or element_count sweep all MAX_DOFS
// entries (4096 by default) with busy high; a numbering request holds busy while it reads
// each of the D usable DOF entries and writes back its number. The clear and numbering
// results are given at the start of their pass. mpc_count writes take effect at once.
module dof_equation_numbering_router
  import dofr_pkg::*;
#(
  parameter int MAX_DOFS  = 4096,
  parameter int NODE_DOFS = 3,
  parameter int ELEM_DOFS = 1,
  parameter int MAX_MPC   = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [12:0]        cfg_data_i,
  input  logic [2:0]         cmd_i,
  input  logic signed [13:0] node_a_i,
  input  logic [2:0]         dof_a_i,
  input  logic signed [13:0] node_b_i,
  input  logic [2:0]         dof_b_i,
  input  logic [8:0]         mpc_index_i,
  input  logic [63:0]        value_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic [2:0]         target_block_o,
  output logic [12:0]        row_index_o,
  output logic [12:0]        col_index_o,
  output logic [63:0]        value_out_o,
  output logic [12:0]        equation_no_o,
  output logic               constrained_flag_o,
  output logic [12:0]        constrained_total_o
);

  `include "dof_equation_numbering_router_assert.svh"

  localparam int AW = $clog2(MAX_DOFS);
  localparam int NW = $clog2(MAX_DOFS + 1);

  typedef struct packed {
    logic          mark;
    logic [NW-1:0] eq;
  } entry_t;

  // Zero-based DOF number of a node or element address, with its range check
  function automatic dof_addr_t dof_decode(
    input logic signed [13:0] node,
    input logic [2:0]         dof,
    input logic [12:0]        n_cnt,
    input logic [12:0]        e_cnt,
    input logic [IXW-1:0]     dmax
  );
    dof_addr_t    r;
    logic [13:0]  mag;
    logic [13:0]  pos;
    begin
      mag = ~node + 14'd1;
      pos = node;
      if (node == 14'sd0) begin
        r.ok  = 1'b0;
        r.idx = '0;
      end else if (node[13]) begin
        r.ok  = (mag <= {1'b0, e_cnt}) && ({1'b0, dof} < 4'(ELEM_DOFS));
        r.idx = IXW'(mag - 14'd1) * IXW'(ELEM_DOFS) + IXW'(dof);
      end else begin
        r.ok  = (pos <= {1'b0, n_cnt}) && ({1'b0, dof} < 4'(NODE_DOFS));
        r.idx = IXW'(e_cnt) * IXW'(ELEM_DOFS) + IXW'(pos - 14'd1) * IXW'(NODE_DOFS)
              + IXW'(dof);
      end
      r.ok = r.ok && (r.idx < dmax);
      return r;
    end
  endfunction

  // Configuration
  logic [12:0] node_count_q, element_count_q;
  logic [8:0]  mpc_count_q;
  logic        cfg_clr;

  // Control state
  state_e        state_q, state_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          numbered_q, numbered_d;
  logic [AW-1:0] clr_ptr_q, clr_ptr_d;
  logic [NW-1:0] num_rd_ptr_q, num_rd_ptr_d;
  logic          num_pend_q, num_pend_d;
  logic [AW-1:0] num_wr_ptr_q, num_wr_ptr_d;
  logic [NW-1:0] next_c_q, next_c_d, next_s_q, next_s_d;
  logic          done_q;
  logic          accept, clr_last, num_issue, num_done;

  // Request held for the response cycle
  cmd_e          cmd_q;
  logic          ok_a_q, ok_b_q;
  logic [AW-1:0] idx_a_q;
  logic [8:0]    mpc_q;
  logic [63:0]   value_q;

  // Table memory
  entry_t        dof_mem_q [MAX_DOFS];
  entry_t        rd_a_q, rd_b_q;
  logic [AW-1:0] rd_addr_a, rd_addr_b, mem_waddr;
  logic          mem_we;
  entry_t        mem_wdata;

  // Address decode
  logic [IXW-1:0] dsum, usable_ix;
  logic [NW-1:0]  usable;
  dof_addr_t      dec_a, dec_b;

  // Response datapath
  logic [NW-1:0]  lo, hi;
  logic           m_ok;
  logic [IXW-1:0] col_c;

  // Result
  status_e     status_q, status_d;
  target_e     target_q, target_d;
  logic [12:0] row_q, row_d, col_q, col_d, eq_q, eq_d, total_q, total_d;
  logic [63:0] vout_q, vout_d;
  logic        flag_q, flag_d;

  assign busy    = (state_q != ST_IDLE);
  assign accept  = start && !busy;
  assign cfg_clr = cfg_we_i && ((cfg_idx_i == REG_NODE_COUNT) ||
                                (cfg_idx_i == REG_ELEMENT_COUNT));

  assign dsum = IXW'(node_count_q) * IXW'(NODE_DOFS)
              + IXW'(element_count_q) * IXW'(ELEM_DOFS);
  assign usable_ix = (dsum > IXW'(MAX_DOFS)) ? IXW'(MAX_DOFS) : dsum;
  assign usable    = NW'(usable_ix);

  assign dec_a = dof_decode(node_a_i, dof_a_i, node_count_q, element_count_q, usable_ix);
  assign dec_b = dof_decode(node_b_i, dof_b_i, node_count_q, element_count_q, usable_ix);

  assign clr_last  = (clr_ptr_q == AW'(MAX_DOFS - 1));
  assign num_issue = (num_rd_ptr_q < usable);
  assign num_done  = !num_issue && !num_pend_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cfg_clr) begin
          state_d = ST_CLEAR;
        end else if (start) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (cmd_q == CMD_CLEAR) begin
          state_d = ST_CLEAR;
        end else if (cmd_q == CMD_NUMBER) begin
          state_d = ST_NUMBER;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (cfg_clr) begin
          state_d = ST_CLEAR;
        end else if (clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_NUMBER: begin
        if (num_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Memory control, state updates and result
  always_comb begin
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    rd_addr_a    = dec_a.idx[AW-1:0];
    rd_addr_b    = dec_b.idx[AW-1:0];
    cnt_d        = cnt_q;
    numbered_d   = numbered_q;
    clr_ptr_d    = clr_ptr_q;
    num_rd_ptr_d = num_rd_ptr_q;
    num_pend_d   = 1'b0;
    num_wr_ptr_d = num_wr_ptr_q;
    next_c_d     = next_c_q;
    next_s_d     = next_s_q;
    lo           = (rd_a_q.eq > rd_b_q.eq) ? rd_b_q.eq : rd_a_q.eq;
    hi           = (rd_a_q.eq > rd_b_q.eq) ? rd_a_q.eq : rd_b_q.eq;
    m_ok         = (mpc_q != 9'd0) && (mpc_q <= mpc_count_q) &&
                   (13'(mpc_q) <= 13'(MAX_MPC));
    col_c        = IXW'(usable) - IXW'(cnt_q) + IXW'(mpc_q);
    status_d     = STATUS_OK;
    target_d     = TGT_NONE;
    row_d        = '0;
    col_d        = '0;
    vout_d       = '0;
    eq_d         = '0;
    flag_d       = 1'b0;

    unique case (state_q)
      ST_IDLE: ;
      ST_RESP: begin
        unique case (cmd_q)
          CMD_CLEAR: begin
            cnt_d      = '0;
            numbered_d = 1'b0;
            clr_ptr_d  = '0;
          end
          CMD_MARK: begin
            if (!ok_a_q) begin
              status_d = STATUS_RANGE;
            end else if (!rd_a_q.mark) begin
              // set a new mark, keep the stored number, invalidate the numbering
              mem_we     = 1'b1;
              mem_waddr  = idx_a_q;
              mem_wdata  = '{mark: 1'b1, eq: rd_a_q.eq};
              cnt_d      = cnt_q + NW'(1);
              numbered_d = 1'b0;
            end
          end
          CMD_NUMBER: begin
            num_rd_ptr_d = '0;
            num_wr_ptr_d = '0;
            next_c_d     = NW'(1);
            next_s_d     = cnt_q + NW'(1);
          end
          CMD_ROUTE_K: begin
            if (!(ok_a_q && ok_b_q)) begin
              status_d = STATUS_RANGE;
            end else if (!numbered_q) begin
              status_d = STATUS_UNNUMBERED;
            end else begin
              vout_d = value_q;
              if (lo <= cnt_q) begin
                row_d = OUT_W'(lo);
                if (hi <= cnt_q) begin
                  target_d = TGT_KCC;
                  col_d    = OUT_W'(hi);
                end else begin
                  target_d = TGT_KCS;
                  col_d    = OUT_W'(hi - cnt_q);
                end
              end else begin
                target_d = TGT_KSSCST;
                row_d    = OUT_W'(lo - cnt_q);
                col_d    = OUT_W'(hi - cnt_q);
              end
            end
          end
          CMD_ROUTE_C: begin
            if (!(ok_b_q && m_ok)) begin
              status_d = STATUS_RANGE;
            end else if (!numbered_q) begin
              status_d = STATUS_UNNUMBERED;
            end else begin
              vout_d = value_q;
              if (rd_b_q.eq <= cnt_q) begin
                target_d = TGT_CC;
                row_d    = OUT_W'(mpc_q);
                col_d    = OUT_W'(rd_b_q.eq);
              end else begin
                target_d = TGT_KSSCST;
                row_d    = OUT_W'(rd_b_q.eq - cnt_q);
                col_d    = OUT_W'(col_c);
              end
            end
          end
          CMD_QUERY: begin
            if (!ok_a_q) begin
              status_d = STATUS_RANGE;
            end else begin
              flag_d = rd_a_q.mark;
              if (!numbered_q) begin
                status_d = STATUS_UNNUMBERED;
              end else begin
                eq_d = OUT_W'(rd_a_q.eq);
              end
            end
          end
          default: status_d = STATUS_RANGE;
        endcase
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_ptr_q;
        mem_wdata = '0;
        clr_ptr_d = clr_ptr_q + AW'(1);
      end
      ST_NUMBER: begin
        // read one entry ahead, write back its number in the next cycle
        if (num_issue) begin
          rd_addr_a    = num_rd_ptr_q[AW-1:0];
          num_rd_ptr_d = num_rd_ptr_q + NW'(1);
          num_pend_d   = 1'b1;
        end
        if (num_pend_q) begin
          mem_we       = 1'b1;
          mem_waddr    = num_wr_ptr_q;
          mem_wdata    = '{mark: rd_a_q.mark, eq: rd_a_q.mark ? next_c_q : next_s_q};
          num_wr_ptr_d = num_wr_ptr_q + AW'(1);
          if (rd_a_q.mark) begin
            next_c_d = next_c_q + NW'(1);
          end else begin
            next_s_d = next_s_q + NW'(1);
          end
        end
        if (num_done) begin
          numbered_d = 1'b1;
        end
      end
      default: ;
    endcase

    if (cfg_clr) begin
      cnt_d      = '0;
      numbered_d = 1'b0;
      clr_ptr_d  = '0;
    end
    total_d = OUT_W'(cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_CLEAR;
      cnt_q           <= '0;
      numbered_q      <= 1'b0;
      clr_ptr_q       <= '0;
      num_rd_ptr_q    <= '0;
      num_pend_q      <= 1'b0;
      num_wr_ptr_q    <= '0;
      next_c_q        <= '0;
      next_s_q        <= '0;
      done_q          <= 1'b0;
      node_count_q    <= '0;
      element_count_q <= '0;
      mpc_count_q     <= '0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      numbered_q   <= numbered_d;
      clr_ptr_q    <= clr_ptr_d;
      num_rd_ptr_q <= num_rd_ptr_d;
      num_pend_q   <= num_pend_d;
      num_wr_ptr_q <= num_wr_ptr_d;
      next_c_q     <= next_c_d;
      next_s_q     <= next_s_d;
      done_q       <= (state_q == ST_RESP);
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_NODE_COUNT:    node_count_q    <= cfg_data_i;
          REG_ELEMENT_COUNT: element_count_q <= cfg_data_i;
          REG_MPC_COUNT:     mpc_count_q     <= cfg_data_i[8:0];
          default: ;
        endcase
      end
    end
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_e'(cmd_i);
      ok_a_q  <= dec_a.ok;
      ok_b_q  <= dec_b.ok;
      idx_a_q <= dec_a.idx[AW-1:0];
      mpc_q   <= mpc_index_i;
      value_q <= value_i;
    end
  end

  // Table memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      dof_mem_q[mem_waddr] <= mem_wdata;
    end
    rd_a_q <= dof_mem_q[rd_addr_a];
    rd_b_q <= dof_mem_q[rd_addr_b];
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RESP) begin
      status_q <= status_d;
      target_q <= target_d;
      row_q    <= row_d;
      col_q    <= col_d;
      vout_q   <= vout_d;
      eq_q     <= eq_d;
      flag_q   <= flag_d;
      total_q  <= total_d;
    end
  end

  assign done_o              = done_q;
  assign status_o            = status_q;
  assign target_block_o      = target_q;
  assign row_index_o         = row_q;
  assign col_index_o         = col_q;
  assign value_out_o         = vout_q;
  assign equation_no_o       = eq_q;
  assign constrained_flag_o  = flag_q;
  assign constrained_total_o = total_q;

  `DOFR_ASSERT_IMP(a_done_from_resp, clk_i, rst_ni, done_q, $past(state_q == ST_RESP), "result strobe without a response cycle")
  `DOFR_ASSERT_IMP(a_numbered_from_pass, clk_i, rst_ni, $rose(numbered_q), $past(state_q == ST_NUMBER), "numbering flag set outside the numbering pass")
  `DOFR_ASSERT_NXT(a_mark_counts, clk_i, rst_ni, (state_q == ST_RESP) && mem_we && !cfg_clr, cnt_q == $past(cnt_q) + NW'(1), "new mark not counted")
  `DOFR_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, cnt_q <= NW'(MAX_DOFS), "constrained count beyond table depth")

endmodule

### bench/tb_dof_equation_numbering_router.sv
module tb_dof_equation_numbering_router;
  timeunit 1ns;
  timeprecision 1ps;

  import dofr_pkg::*;

  localparam int MAX_DOFS     = 4096;
  localparam int NODE_DOFS    = 3;
  localparam int ELEM_DOFS    = 1;
  localparam int MAX_MPC      = 256;
  localparam int LIMIT_CYCLES = 12_000_000;

  // Command codes outside the defined set
  localparam logic [2:0] CMD_RESERVED_A = 3'd6;
  localparam logic [2:0] CMD_RESERVED_B = 3'd7;

  typedef struct {
    logic [2:0]         cmd;
    logic signed [13:0] node_a;
    logic [2:0]         dof_a;
    logic signed [13:0] node_b;
    logic [2:0]         dof_b;
    logic [8:0]         mpc_index;
    logic [63:0]        value;
  } request_t;

  typedef struct {
    status_e     status;
    target_e     target;
    logic [12:0] row;
    logic [12:0] col;
    logic [63:0] value_out;
    logic [12:0] eq;
    logic        flag;
    logic [12:0] total;
  } route_result_t;

  logic               clk_i      = 1'b0;
  logic               rst_ni     = 1'b0;
  logic               start      = 1'b0;
  logic               busy;
  logic               cfg_we_i   = 1'b0;
  logic [1:0]         cfg_idx_i  = '0;
  logic [12:0]        cfg_data_i = '0;
  logic [2:0]         cmd_i      = '0;
  logic signed [13:0] node_a_i   = '0;
  logic [2:0]         dof_a_i    = '0;
  logic signed [13:0] node_b_i   = '0;
  logic [2:0]         dof_b_i    = '0;
  logic [8:0]         mpc_index_i = '0;
  logic [63:0]        value_i    = '0;
  logic               done_o;
  logic [1:0]         status_o;
  logic [2:0]         target_block_o;
  logic [12:0]        row_index_o;
  logic [12:0]        col_index_o;
  logic [63:0]        value_out_o;
  logic [12:0]        equation_no_o;
  logic               constrained_flag_o;
  logic [12:0]        constrained_total_o;

  dof_equation_numbering_router dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .cmd_i               (cmd_i),
    .node_a_i            (node_a_i),
    .dof_a_i             (dof_a_i),
    .node_b_i            (node_b_i),
    .dof_b_i             (dof_b_i),
    .mpc_index_i         (mpc_index_i),
    .value_i             (value_i),
    .done_o              (done_o),
    .status_o            (status_o),
    .target_block_o      (target_block_o),
    .row_index_o         (row_index_o),
    .col_index_o         (col_index_o),
    .value_out_o         (value_out_o),
    .equation_no_o       (equation_no_o),
    .constrained_flag_o  (constrained_flag_o),
    .constrained_total_o (constrained_total_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Own copy of the DOF table and registers
  bit          mark_tbl [MAX_DOFS];
  logic [12:0] eqn_tbl  [MAX_DOFS];
  int          n_nodes, n_elems, n_mpc, fixed_total;
  bit          numbered;

  request_t      pending_q [$];
  route_result_t expected_q [$];
  request_t      cur_req;

  int pushed_cnt, sent_cnt, taken_cnt, checked_cnt, mismatches, cycles, phases;
  int idle_pct;
  int target_hits [5];
  int range_hits, unnumbered_hits;

  function automatic void wipe_marks();
    foreach (mark_tbl[i]) mark_tbl[i] = 1'b0;
    fixed_total = 0;
    numbered    = 1'b0;
  endfunction

  function automatic int usable_dofs();
    int d;
    d = n_nodes * NODE_DOFS + n_elems * ELEM_DOFS;
    return (d > MAX_DOFS) ? MAX_DOFS : d;
  endfunction

  // Zero-based DOF number, -1 for an invalid address
  function automatic int dof_number(logic signed [13:0] node, logic [2:0] dof);
    int n, d, idx;
    n = int'(node);
    d = int'(dof);
    if (n == 0) return -1;
    if (n < 0) begin
      if (-n > n_elems || d >= ELEM_DOFS) return -1;
      idx = (-n - 1) * ELEM_DOFS + d;
    end else begin
      if (n > n_nodes || d >= NODE_DOFS) return -1;
      idx = n_elems * ELEM_DOFS + (n - 1) * NODE_DOFS + d;
    end
    if (idx >= usable_dofs()) return -1;
    return idx;
  endfunction

  function automatic route_result_t route_request(request_t rq);
    route_result_t r;
    int ia, ib, lo, hi, m, cnt, d, nc, ns;
    r.status    = STATUS_OK;
    r.target    = TGT_NONE;
    r.row       = '0;
    r.col       = '0;
    r.value_out = '0;
    r.eq        = '0;
    r.flag      = 1'b0;
    cnt = fixed_total;
    case (rq.cmd)
      CMD_CLEAR: wipe_marks();
      CMD_MARK: begin
        ia = dof_number(rq.node_a, rq.dof_a);
        if (ia < 0) begin
          r.status = STATUS_RANGE;
        end else if (!mark_tbl[ia]) begin
          mark_tbl[ia] = 1'b1;
          fixed_total++;
          numbered = 1'b0;
        end
      end
      CMD_NUMBER: begin
        d  = usable_dofs();
        nc = 1;
        ns = fixed_total + 1;
        for (int i = 0; i < d; i++) begin
          if (mark_tbl[i]) begin
            eqn_tbl[i] = 13'(nc);
            nc++;
          end else begin
            eqn_tbl[i] = 13'(ns);
            ns++;
          end
        end
        numbered = 1'b1;
      end
      CMD_ROUTE_K: begin
        ia = dof_number(rq.node_a, rq.dof_a);
        ib = dof_number(rq.node_b, rq.dof_b);
        if (ia < 0 || ib < 0) begin
          r.status = STATUS_RANGE;
        end else if (!numbered) begin
          r.status = STATUS_UNNUMBERED;
        end else begin
          lo = int'(eqn_tbl[ia]);
          hi = int'(eqn_tbl[ib]);
          if (lo > hi) begin
            lo = int'(eqn_tbl[ib]);
            hi = int'(eqn_tbl[ia]);
          end
          if (lo <= cnt && hi <= cnt) begin
            r.target = TGT_KCC;
            r.row = 13'(lo);
            r.col = 13'(hi);
          end else if (lo <= cnt) begin
            r.target = TGT_KCS;
            r.row = 13'(lo);
            r.col = 13'(hi - cnt);
          end else begin
            r.target = TGT_KSSCST;
            r.row = 13'(lo - cnt);
            r.col = 13'(hi - cnt);
          end
          r.value_out = rq.value;
        end
      end
      CMD_ROUTE_C: begin
        m  = int'(rq.mpc_index);
        ib = dof_number(rq.node_b, rq.dof_b);
        if (ib < 0 || m == 0 || m > n_mpc || m > MAX_MPC) begin
          r.status = STATUS_RANGE;
        end else if (!numbered) begin
          r.status = STATUS_UNNUMBERED;
        end else begin
          hi = int'(eqn_tbl[ib]);
          if (hi <= cnt) begin
            r.target = TGT_CC;
            r.row = 13'(m);
            r.col = 13'(hi);
          end else begin
            // constraint columns sit after the free block
            r.target = TGT_KSSCST;
            r.row = 13'(hi - cnt);
            r.col = 13'(usable_dofs() - cnt + m);
          end
          r.value_out = rq.value;
        end
      end
      CMD_QUERY: begin
        ia = dof_number(rq.node_a, rq.dof_a);
        if (ia < 0) begin
          r.status = STATUS_RANGE;
        end else begin
          r.flag = mark_tbl[ia];
          if (!numbered) r.status = STATUS_UNNUMBERED;
          else r.eq = eqn_tbl[ia];
        end
      end
      default: r.status = STATUS_RANGE;
    endcase
    r.total = 13'(fixed_total);
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Driver: hold a request until taken, otherwise present the next one or idle
  always @(negedge clk_i) begin
    if (!(start && taken_cnt != sent_cnt)) begin
      if (pending_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        cur_req = pending_q.pop_front();
        start       <= 1'b1;
        cmd_i       <= cur_req.cmd;
        node_a_i    <= cur_req.node_a;
        dof_a_i     <= cur_req.dof_a;
        node_b_i    <= cur_req.node_b;
        dof_b_i     <= cur_req.dof_b;
        mpc_index_i <= cur_req.mpc_index;
        value_i     <= cur_req.value;
        sent_cnt++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check results in order, predict each accepted request
  always @(posedge clk_i) begin
    route_result_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_q.size() == 0) begin
          $error("result with no pending request");
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", 64'(want.status), 64'(status_o));
          check_field("target_block", 64'(want.target), 64'(target_block_o));
          check_field("row_index", 64'(want.row), 64'(row_index_o));
          check_field("col_index", 64'(want.col), 64'(col_index_o));
          check_field("value_out", want.value_out, value_out_o);
          check_field("equation_no", 64'(want.eq), 64'(equation_no_o));
          check_field("constrained_flag", 64'(want.flag), 64'(constrained_flag_o));
          check_field("constrained_total", 64'(want.total), 64'(constrained_total_o));
          checked_cnt++;
          if (want.target != TGT_NONE) target_hits[want.target]++;
          if (want.status == STATUS_RANGE) range_hits++;
          if (want.status == STATUS_UNNUMBERED) unnumbered_hits++;
        end
      end
      if (start && !busy) begin
        expected_q.insert(expected_q.size(), route_request(cur_req));
        taken_cnt++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic wait_quiet();
    do @(negedge clk_i);
    while (taken_cnt != pushed_cnt || expected_q.size() != 0 || busy);
  endtask

  task automatic write_reg(cfg_reg_e idx, int data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data[12:0];
    case (idx)
      REG_NODE_COUNT: begin
        n_nodes = data;
        wipe_marks();
      end
      REG_ELEMENT_COUNT: begin
        n_elems = data;
        wipe_marks();
      end
      REG_MPC_COUNT: n_mpc = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_req(logic [2:0] cmd, int na, int da, int nb, int db, int mi,
                           logic [63:0] v);
    request_t rq;
    rq.cmd       = cmd;
    rq.node_a    = na[13:0];
    rq.dof_a     = da[2:0];
    rq.node_b    = nb[13:0];
    rq.dof_b     = db[2:0];
    rq.mpc_index = mi[8:0];
    rq.value     = v;
    pending_q.insert(pending_q.size(), rq);
    pushed_cnt++;
  endtask

  function automatic logic [63:0] rand_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly a DOF that exists in the current mesh, now and then a random node from -4096 to 4096 with any dof
  function automatic void pick_dof(output int node, output int dof);
    if ($urandom_range(0, 99) < 15 || (n_nodes == 0 && n_elems == 0)) begin
      node = int'($urandom_range(0, 8192)) - 4096;
      dof  = $urandom_range(0, 7);
    end else if (n_elems > 0 && (n_nodes == 0 || $urandom_range(0, 3) == 0)) begin
      node = -int'($urandom_range(1, n_elems));
      dof  = $urandom_range(0, ELEM_DOFS - 1);
    end else begin
      node = $urandom_range(1, n_nodes);
      dof  = $urandom_range(0, NODE_DOFS - 1);
    end
  endfunction

  task automatic queue_random(logic [2:0] cmd);
    int na, da, nb, db, mi;
    pick_dof(na, da);
    pick_dof(nb, db);
    if (n_mpc > 0 && $urandom_range(0, 99) < 85) mi = $urandom_range(1, n_mpc);
    else mi = $urandom_range(0, MAX_MPC);
    queue_req(cmd, na, da, nb, db, mi, rand_value());
  endtask

  // Optional clear, marks, numbering, then routing and queries with marks, renumbering and clears mixed in
  task automatic gen_session(int n_req);
    int k, roll;
    if ($urandom_range(0, 3) == 0) begin
      queue_random(CMD_CLEAR);
      n_req--;
    end
    k = $urandom_range(0, n_req / 3);
    repeat (k) queue_random(CMD_MARK);
    queue_random(CMD_NUMBER);
    repeat (n_req - k - 1) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) queue_random(CMD_ROUTE_K);
      else if (roll < 65) queue_random(CMD_ROUTE_C);
      else if (roll < 85) queue_random(CMD_QUERY);
      else if (roll < 92) queue_random(CMD_MARK);
      else if (roll < 96) queue_random(CMD_NUMBER);
      else if (roll < 98) queue_random(CMD_CLEAR);
      else queue_random(CMD_QUERY);
    end
  endtask

  task automatic run_phase(int nn, int ne, int nm, bit mpc_only, int n_req, int idle);
    int made, sz;
    wait_quiet();
    if (!mpc_only) begin
      write_reg(REG_NODE_COUNT, nn);
      write_reg(REG_ELEMENT_COUNT, ne);
    end
    write_reg(REG_MPC_COUNT, nm);
    // let the clearing sweep start before looking at busy
    repeat (2) @(negedge clk_i);
    wait_quiet();
    idle_pct = idle;
    phases++;
    made = 0;
    while (made < n_req) begin
      sz = $urandom_range(10, 40);
      if (sz > n_req - made) sz = n_req - made;
      gen_session(sz);
      made += sz;
      // hold the sender once per phase until everything has come back
      if (made == sz) wait_quiet();
    end
  endtask

  initial begin
    idle_pct = 18;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);
    wait_quiet();

    // Small mesh: two elements then four nodes, fourteen DOFs
    write_reg(REG_NODE_COUNT, 4);
    write_reg(REG_ELEMENT_COUNT, 2);
    write_reg(REG_MPC_COUNT, 3);
    repeat (2) @(negedge clk_i);
    wait_quiet();
    phases++;
    queue_req(CMD_QUERY, 1, 0, 0, 0, 1, '0);
    queue_req(CMD_ROUTE_K, 1, 0, 2, 1, 1, '1);
    queue_req(CMD_MARK, -1, 0, 0, 0, 0, '0);
    queue_req(CMD_MARK, 4, 2, 0, 0, 0, '0);
    queue_req(CMD_MARK, 4, 2, 0, 0, 0, '0);
    queue_req(CMD_MARK, 0, 0, 0, 0, 0, '0);
    queue_req(CMD_MARK, 4096, 0, 0, 0, 0, '0);
    queue_req(CMD_MARK, 1, 3, 0, 0, 0, '0);
    queue_req(CMD_MARK, -4096, 0, 0, 0, 0, '0);
    queue_req(CMD_MARK, -2, 7, 0, 0, 0, '0);
    queue_req(CMD_NUMBER, 0, 0, 0, 0, 0, '0);
    queue_req(CMD_QUERY, 4, 2, 0, 0, 0, '0);
    queue_req(CMD_ROUTE_K, -1, 0, 4, 2, 0, 64'h0123_4567_89ab_cdef);
    queue_req(CMD_ROUTE_K, 4, 2, 1, 0, 0, 64'h8000_0000_0000_0001);
    queue_req(CMD_ROUTE_K, 3, 0, 2, 1, 0, '1);
    queue_req(CMD_MARK, 2, 0, 0, 0, 0, '0);
    queue_req(CMD_ROUTE_K, -4096, 0, 1, 0, 0, '1);
    queue_req(CMD_ROUTE_K, 1, 0, 2, 2, 0, '1);
    queue_req(CMD_NUMBER, 0, 0, 0, 0, 0, '0);
    queue_req(CMD_ROUTE_C, 0, 0, -1, 0, 1, 64'hdead_beef_0000_ffff);
    queue_req(CMD_ROUTE_C, 4096, 7, 4, 0, 3, '1);
    queue_req(CMD_ROUTE_C, 0, 0, 4, 0, 0, '1);
    queue_req(CMD_ROUTE_C, -4096, 7, 4, 0, 256, '1);
    queue_req(CMD_RESERVED_A, 1, 0, 1, 0, 1, '1);
    queue_req(CMD_RESERVED_B, 1, 0, 1, 0, 1, '1);
    queue_req(CMD_CLEAR, 0, 0, 0, 0, 0, '0);
    queue_req(CMD_QUERY, 4, 2, 0, 0, 0, '0);

    run_phase(4096, 4096, MAX_MPC, 1'b0, 40, 18);
    run_phase(0, 0, 0, 1'b0, 25, 18);
    run_phase(9, 6, 4, 1'b0, 150, 18);
    run_phase(0, 0, MAX_MPC, 1'b1, 100, 82);
    run_phase(0, 5, 1, 1'b0, 40, 82);
    run_phase(20, 0, 100, 1'b0, 130, 82);
    run_phase(4096, 0, MAX_MPC, 1'b0, 35, 0);
    run_phase($urandom_range(1, 30), $urandom_range(0, 12), $urandom_range(1, MAX_MPC),
              1'b0, 150, 0);
    run_phase(3, 1, 2, 1'b0, 130, 0);

    wait_quiet();
    repeat (8) @(negedge clk_i);
    if (expected_q.size() != 0) begin
      $error("%0d results never arrived", expected_q.size());
      mismatches++;
    end

    $display("%0d requests over %0d register settings, %0d results checked, %0d mismatches",
             taken_cnt, phases, checked_cnt, mismatches);
    $display("routed Kcc %0d, Kcs %0d, KssCsT %0d, Cc %0d; range errors %0d, unnumbered %0d",
             target_hits[TGT_KCC], target_hits[TGT_KCS], target_hits[TGT_KSSCST],
             target_hits[TGT_CC], range_hits, unnumbered_hits);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/dofr_pkg.sv
design/dof_equation_numbering_router.sv
bench/tb_dof_equation_numbering_router.sv
